[src/sbc_pkg.sv]
package sbc_pkg;

  localparam int ROUNDS    = 44;
  localparam int KEY_WORDS = 4;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = $clog2(ROUNDS);
  localparam int KIDX_W    = $clog2(KEY_WORDS);
  localparam int CFG_IDX_W = 4;

  localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(ROUNDS - 1);

  // Operation codes carried in the cmd field
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // Round constant sequence z3, element 0 first
  localparam logic Z3_SEQ [0:61] = '{
    1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
    1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b1, 1'b1, 1'b1
  };

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] block_x;
    logic [WORD_W-1:0] block_y;
  } sbc_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_x;
    logic [WORD_W-1:0] out_y;
  } sbc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PREP,
    ST_RUN,
    ST_FINISH
  } sbc_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              key_wr;
    logic [KIDX_W-1:0] key_idx;
    logic              load_blk;
    logic              exp_en;
    logic [CNT_W-1:0]  exp_cnt;
    logic              round_en;
    logic [CNT_W-1:0]  rk_addr;
    logic              load_out;
  } sbc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mode;
  } sbc_sts_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
    rotl = (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int n);
    rotr = (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] a);
    round_f = (rotl(a, 1) & rotl(a, 8)) ^ rotl(a, 2);
  endfunction

endpackage

[src/simon_block_cipher.sv]
// Simon 64/128 block cipher, one round per clock from a round key RAM.
// An input transfer is followed by a registered key read, the 44 rounds and a
// result load, which waits while out_stall holds a prior result; a new item is
// taken only once the block is back in idle after that load.
// A key word write starts the key expansion; input and config are
// held off until it ends. Synchronous active-low reset clears the controller
// and key words; the round key store holds nothing until a key word is written.
module simon_block_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sbc_pkg::sbc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sbc_pkg::sbc_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbc_pkg::WORD_W-1:0]    cfg_data
);

  import sbc_pkg::*;

  sbc_cmd_t cmd;
  sbc_sts_t sts;

  sbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

[src/sbc_ram.sv]
module sbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

endmodule

[src/sbc_ctrl.sv]
module sbc_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  output logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  sbc_pkg::sbc_sts_t                sts,
  output sbc_pkg::sbc_cmd_t                cmd
);

  import sbc_pkg::*;

  sbc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] rd_idx;
  logic             key_hit;

  assign out_valid = out_valid_r;
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign key_hit   = cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(KEY_WORDS));

  // Hold state, round counter and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    rd_idx        = '0;
    cmd           = '0;
    cmd.key_wr    = key_hit;
    cmd.key_idx   = cfg_index[KIDX_W-1:0];
    cmd.exp_cnt   = cnt_r;

    // Drop the result once transferred
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (key_hit) begin
          state_nxt = ST_EXPAND;
        end else if (in_valid && !in_stall) begin
          cmd.load_blk = 1'b1;
          state_nxt    = ST_PREP;
        end
      end
      ST_EXPAND: begin
        cmd.exp_en = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == LAST_ROUND) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_PREP: begin
        rd_idx    = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.round_en = 1'b1;
        rd_idx       = cnt_r + 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_ROUND) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Walk the round keys backward for decryption
    cmd.rk_addr = (sts.mode == CMD_DECRYPT) ? (LAST_ROUND - rd_idx) : rd_idx;
  end

endmodule

[src/sbc_dp.sv]
module sbc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sbc_pkg::sbc_in_t               in_data,
  output sbc_pkg::sbc_out_t              out_data,
  input  logic [sbc_pkg::WORD_W-1:0]     cfg_data,
  input  sbc_pkg::sbc_cmd_t              cmd,
  output sbc_pkg::sbc_sts_t              sts
);

  import sbc_pkg::*;

  logic [WORD_W-1:0] key_r [KEY_WORDS];
  logic [WORD_W-1:0] win_r [KEY_WORDS];
  logic [WORD_W-1:0] x_r, x_nxt;
  logic [WORD_W-1:0] y_r, y_nxt;
  logic              mode_r;
  sbc_out_t          out_r;
  logic [WORD_W-1:0] rk;
  logic [WORD_W-1:0] exp_t;
  logic [WORD_W-1:0] exp_mix;
  logic [WORD_W-1:0] new_key;
  logic [CNT_W-1:0]  z_idx;

  assign sts.mode = mode_r;
  assign out_data = out_r;

  // Key word registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cmd.key_wr) begin
      key_r[cmd.key_idx] <= cfg_data;
    end
  end

  // Next round key: a key word while the count is below four, else from the last four
  always_comb begin
    z_idx   = cmd.exp_cnt - CNT_W'(KEY_WORDS);
    exp_t   = rotr(win_r[KEY_WORDS-1], 3) ^ win_r[1];
    exp_mix = exp_t ^ rotr(exp_t, 1);
    if (cmd.exp_cnt < CNT_W'(KEY_WORDS)) begin
      new_key = key_r[cmd.exp_cnt[KIDX_W-1:0]];
    end else begin
      new_key = ~win_r[0] ^ exp_mix ^ {{(WORD_W-1){1'b0}}, Z3_SEQ[z_idx]}
                ^ WORD_W'(3);
    end
  end

  // Advance the key window during expansion
  always_ff @(posedge clk) begin
    if (cmd.exp_en) begin
      for (int i = 0; i < KEY_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[KEY_WORDS-1] <= new_key;
    end
  end

  sbc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUNDS)
  ) u_rk_ram (
    .clk     (clk),
    .we      (cmd.exp_en),
    .waddr   (cmd.exp_cnt),
    .wdata   (new_key),
    .raddr   (cmd.rk_addr),
    .rdata_r (rk)
  );

  // One Feistel round
  always_comb begin
    if (mode_r == CMD_DECRYPT) begin
      x_nxt = y_r;
      y_nxt = x_r ^ round_f(y_r) ^ rk;
    end else begin
      x_nxt = y_r ^ round_f(x_r) ^ rk;
      y_nxt = x_r;
    end
  end

  // Hold the block halves, load on transfer, advance per round
  always_ff @(posedge clk) begin
    if (cmd.load_blk) begin
      x_r    <= in_data.block_x;
      y_r    <= in_data.block_y;
      mode_r <= in_data.cmd;
    end else if (cmd.round_en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.out_x <= x_r;
      out_r.out_y <= y_r;
    end
  end

endmodule
